### rtl/kct_pkg.sv
`default_nettype none
package kct_pkg;
    localparam int MaxKeys = 32;
    localparam int IdxW = $clog2(MaxKeys);
    localparam int CntW = $clog2(MaxKeys + 1);

    localparam logic [1:0] ModeClear  = 2'd0;
    localparam logic [1:0] ModeInsert = 2'd1;
    localparam logic [1:0] ModeDelete = 2'd2;
    localparam logic [1:0] ModeEval   = 2'd3;

    localparam logic [1:0] StatOk      = 2'd0;
    localparam logic [1:0] StatFull    = 2'd1;
    localparam logic [1:0] StatNoMatch = 2'd2;

    typedef struct packed {
        logic [31:0] frame;
        logic [31:0] value;
        logic [31:0] slope;
    } t_key;

    // product unit request/answer
    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
        logic [5:0]  shift;
        logic        rnd;
    } t_mul_req;

    typedef struct packed {
        logic        done;
        logic [63:0] prod;
    } t_mul_rsp;
endpackage
`default_nettype wire

### rtl/kct_mul.sv
`default_nettype none
// sequential signed multiply, 16 bits of |b| per cycle, with shift and rounding
module kct_mul (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire kct_pkg::t_mul_req i_req,
    output kct_pkg::t_mul_rsp      o_rsp
);
    logic        r_busy, n_busy;
    logic [1:0]  r_step, n_step;
    logic        r_neg, n_neg;
    logic [63:0] r_a, n_a;
    logic [63:0] r_b, n_b;
    logic [127:0] r_acc, n_acc;
    logic [5:0]  r_sh, n_sh;
    logic        r_rnd, n_rnd;
    logic        r_done, n_done;
    logic [63:0] r_prod, n_prod;
    logic [127:0] w_r;
    logic [63:0] w_m;
    logic [63:0] w_pp;

    always_comb begin
        n_busy = r_busy; n_step = r_step; n_neg = r_neg; n_a = r_a; n_b = r_b;
        n_acc = r_acc; n_sh = r_sh; n_rnd = r_rnd; n_done = 1'b0; n_prod = r_prod;
        w_r = '0; w_m = '0; w_pp = '0;
        if (i_req.start) begin
            n_busy = 1'b1; n_step = 2'd0;
            n_neg = i_req.a[63] ^ i_req.b[63];
            n_a = i_req.a[63] ? -i_req.a : i_req.a;
            n_b = i_req.b[63] ? -i_req.b : i_req.b;
            n_acc = '0; n_sh = i_req.shift; n_rnd = i_req.rnd;
        end else if (r_busy) begin
            // a is below 2^48 for every use, one 48x16 partial product a cycle
            w_pp = {16'd0, r_a[47:0]} * {48'd0, r_b[15:0]};
            n_acc = r_acc + ({64'd0, w_pp} << {r_step, 4'd0});
            n_b = r_b >> 16;
            n_step = r_step + 2'd1;
            if (r_step == 2'd3) begin
                n_busy = 1'b0;
                n_done = 1'b1;
                w_r = n_acc;
                if (r_rnd && r_sh != 6'd0) w_r = w_r + (128'd1 << (r_sh - 6'd1));
                w_r = w_r >> r_sh;
                w_m = w_r[63:0];
                n_prod = r_neg ? -w_m : w_m;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_step <= '0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_step <= n_step;
        end
        r_neg <= n_neg; r_a <= n_a; r_b <= n_b; r_acc <= n_acc;
        r_sh <= n_sh; r_rnd <= n_rnd; r_prod <= n_prod;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_prod;
endmodule
`default_nettype wire

### rtl/kct_div.sv
`default_nettype none
// restoring divider, one quotient bit per cycle: q = (num << 30) / den
module kct_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [32:0] i_num,
    input  wire logic [32:0] i_den,
    output logic             o_done,
    output logic [31:0]      o_quot
);
    logic        r_busy;
    logic [5:0]  r_cnt;
    logic [63:0] r_num;
    logic [33:0] r_rem;
    logic [32:0] r_den;
    logic [63:0] r_q;
    logic        r_done;
    logic [33:0] w_try;
    logic [33:0] w_sub;

    assign w_try = {r_rem[32:0], r_num[63]};
    assign w_sub = w_try - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == 6'd0);
            if (i_start) begin
                r_busy <= 1'b1; r_cnt <= 6'd63;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) r_busy <= 1'b0;
            end
        end
        if (i_start) begin
            r_num <= {1'b0, i_num, 30'd0};
            r_rem <= '0; r_den <= i_den; r_q <= '0;
        end else if (r_busy) begin
            r_num <= r_num << 1;
            if (!w_sub[33]) begin
                r_rem <= w_sub; r_q <= {r_q[62:0], 1'b1};
            end else begin
                r_rem <= w_try; r_q <= {r_q[62:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q[31:0];
endmodule
`default_nettype wire

### rtl/keyframe_curve_table.sv
`default_nettype none
// channel   dir  content
// s_axis    in   tuser: mode[1:0]
//                tdata: frame[31:0], key_value[63:32], key_slope[95:64]
// m_axis    out  tuser: status[1:0]
//                tdata: result_value[31:0], key_count[37:32]
// cfg       in   i_cfg_we / i_cfg_wdata: match_tolerance
// one item at a time; clear goes straight to the output state, insert and
// delete walk the key table key by key (one read and one write memory port)
// evaluate: bound checks against the first and last keys, a search key by key,
// a divide and eight multiplies
// reset clears the key count and the tolerance goes to 4; key memory is not cleared
// a waiting result blocks the next item until taken
module keyframe_curve_table (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [95:0]  s_axis_tdata,  // frame, key_value, key_slope
    input  wire logic [1:0]   s_axis_tuser,  // mode
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [39:0]       m_axis_tdata,  // result_value, key_count
    output logic [1:0]        m_axis_tuser,  // status
    input  wire logic         i_cfg_we,
    input  wire logic [15:0]  i_cfg_wdata
);
    localparam int IW = kct_pkg::IdxW;
    localparam int CW = kct_pkg::CntW;

    localparam logic [4:0] S_IDLE = 5'd0, S_INS_RD = 5'd1, S_INS_CHK = 5'd2,
        S_DEL_RD = 5'd4, S_DEL_CHK = 5'd5, S_DEL_RD2 = 5'd6,
        S_DEL_WR = 5'd7, S_EV_RD = 5'd8, S_EV_CHK = 5'd9, S_EV_DIV = 5'd10,
        S_EV_M = 5'd11, S_OUT = 5'd12, S_EV_FIRST = 5'd13, S_EV_LAST = 5'd14,
        S_EV_PREV = 5'd15;

    kct_pkg::t_key r_mem [kct_pkg::MaxKeys];
    kct_pkg::t_key r_rd;
    logic [IW-1:0] w_raddr, w_waddr;
    logic          w_we;
    kct_pkg::t_key w_wd;

    logic [4:0]  r_st;
    logic [15:0] r_tol;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_i;
    logic [1:0]  r_mode;
    logic signed [31:0] r_f;
    kct_pkg::t_key r_new, r_hold, r_k0, r_k1;
    logic [31:0] r_res;
    logic [1:0]  r_stat;
    logic        r_ovalid;
    logic [3:0]  r_ms;
    logic        r_mwait;
    logic signed [63:0] r_t, r_t2, r_t3, r_rng, r_sum, r_tmp;
    logic        r_dstart;

    kct_pkg::t_mul_req w_mreq;
    kct_pkg::t_mul_rsp w_mrsp;
    logic        w_ddone;
    logic [31:0] w_q;
    logic signed [32:0] w_diff;
    logic signed [63:0] w_h00, w_h01, w_h10, w_h11;
    logic        w_ins_move;
    logic        w_ev_hit;

    assign w_diff = $signed({r_rd.frame[31], r_rd.frame}) - $signed({r_f[31], r_f});
    assign w_h00 = 2 * r_t3 - 3 * r_t2 + 64'sd1073741824;
    assign w_h01 = 3 * r_t2 - 2 * r_t3;
    assign w_h10 = r_t3 - 2 * r_t2 + r_t;
    assign w_h11 = r_t3 - r_t2;
    // once the ripple has started the held key differs from the new one
    assign w_ins_move = (r_i < r_cnt) &&
        ($signed(r_rd.frame) > $signed(r_hold.frame) || r_hold != r_new);
    assign w_ev_hit = $signed(r_rd.frame) >= r_f;

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wd;
        r_rd <= r_mem[w_raddr];
    end

    kct_mul u_mul (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_mreq), .o_rsp(w_mrsp));
    kct_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart),
        .i_num({1'b0, 32'(r_f - $signed(r_k0.frame))}), .i_den(r_rng[32:0]),
        .o_done(w_ddone), .o_quot(w_q));

    // memory addressing and write data
    always_comb begin
        w_raddr = r_i[IW-1:0];
        w_we = 1'b0; w_waddr = r_i[IW-1:0]; w_wd = r_new;
        case (r_st)
            S_DEL_WR: begin
                w_we = 1'b1; w_wd = r_rd; w_waddr = IW'(r_i - CW'(1));
            end
            S_EV_LAST: w_raddr = IW'(r_cnt - CW'(1));
            S_EV_FIRST: w_raddr = '0;
            default: ;
        endcase
        if (r_st == S_INS_CHK && (!(r_i < r_cnt) || w_ins_move)) begin
            w_we = 1'b1; w_wd = r_hold;
        end
    end

    // multiply schedule
    always_comb begin
        w_mreq = '0;
        w_mreq.start = (r_st == S_EV_M) && !r_mwait;
        w_mreq.rnd = 1'b1; w_mreq.shift = 6'd30;
        case (r_ms)
            4'd0: begin w_mreq.a = r_t; w_mreq.b = r_t; w_mreq.rnd = 1'b0; end
            4'd1: begin w_mreq.a = r_t2; w_mreq.b = r_t; w_mreq.rnd = 1'b0; end
            4'd2: begin w_mreq.a = w_h00; w_mreq.b = 64'($signed(r_k0.value)); end
            4'd3: begin w_mreq.a = w_h01; w_mreq.b = 64'($signed(r_k1.value)); end
            4'd4: begin w_mreq.a = w_h10; w_mreq.b = r_rng; end
            4'd5: begin
                w_mreq.a = r_tmp; w_mreq.b = 64'($signed(r_k0.slope)); w_mreq.shift = 6'd12;
            end
            4'd6: begin w_mreq.a = w_h11; w_mreq.b = r_rng; end
            default: begin
                w_mreq.a = r_tmp; w_mreq.b = 64'($signed(r_k1.slope)); w_mreq.shift = 6'd12;
            end
        endcase
    end

    assign s_axis_tready = (r_st == S_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = {2'b00, 6'(r_cnt), r_res};
    assign m_axis_tuser = r_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_tol <= 16'd4; r_cnt <= '0; r_ovalid <= 1'b0;
            r_mwait <= 1'b0; r_ms <= '0; r_dstart <= 1'b0;
        end else begin
            r_dstart <= (r_st == S_EV_CHK) && w_ev_hit;
            if (i_cfg_we) r_tol <= i_cfg_wdata;
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            case (r_st)
                S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    r_mode <= s_axis_tuser;
                    r_f <= s_axis_tdata[31:0];
                    r_new <= {s_axis_tdata[31:0], s_axis_tdata[63:32], s_axis_tdata[95:64]};
                    r_hold <= {s_axis_tdata[31:0], s_axis_tdata[63:32], s_axis_tdata[95:64]};
                    r_res <= '0; r_stat <= kct_pkg::StatOk; r_i <= '0;
                    case (s_axis_tuser)
                        kct_pkg::ModeClear: begin r_cnt <= '0; r_st <= S_OUT; end
                        kct_pkg::ModeInsert:
                            if (r_cnt >= CW'(kct_pkg::MaxKeys)) begin
                                r_stat <= kct_pkg::StatFull; r_st <= S_OUT;
                            end else r_st <= S_INS_RD;
                        kct_pkg::ModeDelete: r_st <= S_DEL_RD;
                        default:
                            if (r_cnt == '0) r_st <= S_OUT;
                            else r_st <= S_EV_FIRST;
                    endcase
                end
                // insert: scan until frame > new, then ripple keys up one slot
                S_INS_RD: r_st <= S_INS_CHK;
                S_INS_CHK: begin
                    if (!(r_i < r_cnt)) begin
                        r_cnt <= r_cnt + CW'(1); r_st <= S_OUT;
                    end else begin
                        if (w_ins_move) r_hold <= r_rd;
                        r_i <= r_i + CW'(1); r_st <= S_INS_RD;
                    end
                end
                S_DEL_RD: begin
                    if (r_i < r_cnt) r_st <= S_DEL_CHK;
                    else begin r_stat <= kct_pkg::StatNoMatch; r_st <= S_OUT; end
                end
                S_DEL_CHK: begin
                    if ((w_diff[32] ? -w_diff : w_diff) < $signed({17'd0, r_tol})) begin
                        r_i <= r_i + CW'(1); r_st <= S_DEL_RD2;
                    end else begin
                        r_i <= r_i + CW'(1); r_st <= S_DEL_RD;
                    end
                end
                // shift remaining keys down one slot
                S_DEL_RD2: begin
                    if (r_i < r_cnt) r_st <= S_DEL_WR;
                    else begin r_cnt <= r_cnt - CW'(1); r_st <= S_OUT; end
                end
                S_DEL_WR: begin r_i <= r_i + CW'(1); r_st <= S_DEL_RD2; end
                S_EV_FIRST: r_st <= S_EV_LAST;
                S_EV_LAST: begin
                    if (r_cnt == CW'(1) || w_ev_hit) begin
                        r_res <= r_rd.value; r_st <= S_OUT;
                    end else r_st <= S_EV_PREV;
                    // first key is the lower neighbor until the scan moves on
                    r_k0 <= r_rd;
                    r_i <= CW'(1);
                end
                S_EV_PREV: begin
                    if ($signed(r_rd.frame) <= r_f) begin
                        r_res <= r_rd.value; r_st <= S_OUT;
                    end else r_st <= S_EV_RD;
                end
                S_EV_RD: r_st <= S_EV_CHK;
                S_EV_CHK: begin
                    if (w_ev_hit) begin
                        r_k1 <= r_rd;
                        r_rng <= 64'($signed(r_rd.frame)) - 64'($signed(r_k0.frame));
                        r_st <= S_EV_DIV;
                    end else begin
                        r_k0 <= r_rd; r_i <= r_i + CW'(1); r_st <= S_EV_RD;
                    end
                end
                S_EV_DIV: if (w_ddone) begin
                    r_t <= {32'd0, w_q}; r_ms <= '0; r_sum <= '0; r_st <= S_EV_M;
                end
                S_EV_M: begin
                    if (!r_mwait) r_mwait <= 1'b1;
                    else if (w_mrsp.done) begin
                        r_mwait <= 1'b0;
                        r_ms <= r_ms + 4'd1;
                        case (r_ms)
                            4'd0: r_t2 <= w_mrsp.prod;
                            4'd1: r_t3 <= w_mrsp.prod;
                            4'd4, 4'd6: r_tmp <= w_mrsp.prod;
                            4'd7: begin
                                r_sum <= r_sum + w_mrsp.prod;
                                r_st <= S_OUT;
                            end
                            default: r_sum <= r_sum + w_mrsp.prod;
                        endcase
                    end
                end
                S_OUT: begin
                    if (r_mode == kct_pkg::ModeEval && r_cnt > CW'(1) && r_ms == 4'd8) begin
                        if (r_sum > 64'sd2147483647) r_res <= 32'h7fffffff;
                        else if (r_sum < -64'sd2147483648) r_res <= 32'h80000000;
                        else r_res <= r_sum[31:0];
                    end
                    r_ms <= '0;
                    r_ovalid <= 1'b1; r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [95:0]  s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [39:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         i_cfg_we;
    logic [15:0]  i_cfg_wdata;

    keyframe_curve_table u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    typedef struct packed {
        logic [5:0]  count;
        logic [1:0]  status;
        logic [31:0] value;
    } t_answer;

    // curve state mirrored in the testbench
    logic signed [63:0] curve_frame [kct_pkg::MaxKeys];
    logic signed [63:0] curve_value [kct_pkg::MaxKeys];
    logic signed [63:0] curve_slope [kct_pkg::MaxKeys];
    int                 curve_count;
    logic [15:0]        tolerance;

    t_answer answer_queue[$];
    int      error_count;
    bit      send_idle_on;
    bit      recv_idle_on;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #400ms;
        $display("testbench: done, errors");
        $finish;
    end

    function automatic logic signed [63:0] round_mul(input logic signed [63:0] a,
                                                     input logic signed [63:0] b,
                                                     input int s);
        logic        neg;
        logic [63:0] ua;
        logic [63:0] ub;
        logic [63:0] r;
        neg = (a < 0) != (b < 0);
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        r = (ua * ub + (64'd1 << (s - 1))) >> s;
        return neg ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [31:0] curve_at(input logic signed [63:0] f);
        int                 k;
        logic signed [63:0] f0, span, t, t2, t3, h00, h01, h10, h11, sum;
        logic [63:0]        num;
        if (curve_count == 0) return 0;
        if (curve_count == 1 || f <= curve_frame[0]) return curve_value[0][31:0];
        if (f >= curve_frame[curve_count-1]) return curve_value[curve_count-1][31:0];
        k = curve_count - 1;
        for (int i = 1; i < curve_count; i++) begin
            if (curve_frame[i] >= f) begin
                k = i;
                break;
            end
        end
        f0 = curve_frame[k-1];
        span = curve_frame[k] - f0;
        num = 64'(f - f0) << 30;
        t = $signed(num / 64'(span));
        t2 = $signed((64'(t) * 64'(t)) >> 30);
        t3 = $signed((64'(t2) * 64'(t)) >> 30);
        h00 = 2 * t3 - 3 * t2 + (64'sd1 <<< 30);
        h01 = 3 * t2 - 2 * t3;
        h10 = t3 - 2 * t2 + t;
        h11 = t3 - t2;
        sum = round_mul(h00, curve_value[k-1], 30) + round_mul(h01, curve_value[k], 30)
            + round_mul(round_mul(h10, span, 30), curve_slope[k-1], 12)
            + round_mul(round_mul(h11, span, 30), curve_slope[k], 12);
        if (sum > 64'sd2147483647) sum = 64'sd2147483647;
        if (sum < -64'sd2147483648) sum = -64'sd2147483648;
        return sum[31:0];
    endfunction

    function automatic t_answer apply_command(input logic [1:0] mode,
                                              input logic [31:0] frame,
                                              input logic [31:0] kval,
                                              input logic [31:0] kslope);
        t_answer            a;
        logic signed [63:0] f;
        logic signed [63:0] d;
        int                 pos;
        int                 hit;
        f = $signed(frame);
        a = '0;
        case (mode)
            kct_pkg::ModeClear: begin
                curve_count = 0;
            end
            kct_pkg::ModeInsert: begin
                if (curve_count >= kct_pkg::MaxKeys) begin
                    a.status = kct_pkg::StatFull;
                end else begin
                    pos = curve_count;
                    for (int i = 0; i < curve_count; i++) begin
                        if (curve_frame[i] > f) begin
                            pos = i;
                            break;
                        end
                    end
                    for (int i = curve_count; i > pos; i--) begin
                        curve_frame[i] = curve_frame[i-1];
                        curve_value[i] = curve_value[i-1];
                        curve_slope[i] = curve_slope[i-1];
                    end
                    curve_frame[pos] = f;
                    curve_value[pos] = $signed(kval);
                    curve_slope[pos] = $signed(kslope);
                    curve_count++;
                end
            end
            kct_pkg::ModeDelete: begin
                hit = -1;
                for (int i = 0; i < curve_count; i++) begin
                    d = curve_frame[i] - f;
                    if (d < 0) d = -d;
                    if (d < $signed({48'd0, tolerance})) begin
                        hit = i;
                        break;
                    end
                end
                if (hit < 0) begin
                    a.status = kct_pkg::StatNoMatch;
                end else begin
                    for (int i = hit; i + 1 < curve_count; i++) begin
                        curve_frame[i] = curve_frame[i+1];
                        curve_value[i] = curve_value[i+1];
                        curve_slope[i] = curve_slope[i+1];
                    end
                    curve_count--;
                end
            end
            default: begin
                a.value = curve_at(f);
            end
        endcase
        a.count = 6'(curve_count);
        return a;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    endtask

    // result side: random stalls and field checks
    initial begin
        int stall;
        t_answer got;
        t_answer want;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                got.value = m_axis_tdata[31:0];
                got.count = m_axis_tdata[37:32];
                got.status = m_axis_tuser;
                if (answer_queue.size() == 0) begin
                    report_mismatch("unexpected item", got.value, 32'd0);
                end else begin
                    want = answer_queue.pop_front();
                    if (got.value !== want.value)
                        report_mismatch("result_value", got.value, want.value);
                    if (got.status !== want.status)
                        report_mismatch("status", 32'(got.status), 32'(want.status));
                    if (got.count !== want.count)
                        report_mismatch("key_count", 32'(got.count), 32'(want.count));
                end
            end
            if (stall > 0) begin
                stall--;
                m_axis_tready <= 1'b0;
            end else if (recv_idle_on && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 11) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // valid stays up after acceptance until the next item or an idle wait replaces it
    task automatic send_command(input logic [1:0] mode, input logic [31:0] frame,
                                input logic [31:0] kval, input logic [31:0] kslope);
        int      gap;
        t_answer next_answer;
        if (send_idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 11);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {kslope, kval, frame};
        s_axis_tuser <= mode;
        next_answer = apply_command(mode, frame, kval, kslope);
        answer_queue.insert(answer_queue.size(), next_answer);
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (answer_queue.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_tolerance(input logic [15:0] v);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        tolerance = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            default: return $urandom();
        endcase
    endfunction

    task automatic test_directed();
        send_command(kct_pkg::ModeEval, 32'h0000_1000, 0, 0);
        send_command(kct_pkg::ModeDelete, 32'h0, 0, 0);
        send_command(kct_pkg::ModeInsert, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
        send_command(kct_pkg::ModeEval, 32'h7fff_ffff, 0, 0);
        send_command(kct_pkg::ModeInsert, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        send_command(kct_pkg::ModeEval, 32'h0000_0000, 0, 0);
        send_command(kct_pkg::ModeEval, 32'h8000_0000, 0, 0);
        send_command(kct_pkg::ModeEval, 32'h7fff_ffff, 0, 0);
        send_command(kct_pkg::ModeInsert, 32'h0000_0000, 32'h0001_0000, 32'h0002_0000);
        send_command(kct_pkg::ModeInsert, 32'h0000_0000, 32'h0003_0000, 32'hfffe_0000);
        send_command(kct_pkg::ModeEval, 32'h0000_0000, 0, 0);
        send_command(kct_pkg::ModeEval, 32'h0000_0800, 0, 0);
        send_command(kct_pkg::ModeDelete, 32'h0000_0003, 0, 0);
        send_command(kct_pkg::ModeDelete, 32'h0000_0004, 0, 0);
        send_command(kct_pkg::ModeClear, 0, 0, 0);
        // fill past capacity
        for (int i = 0; i < kct_pkg::MaxKeys + 2; i++)
            send_command(kct_pkg::ModeInsert, $urandom_range(0, 65535) << 8,
                         rand_word(), rand_word());
        send_command(kct_pkg::ModeEval, 32'h0080_0000, 0, 0);
    endtask

    task automatic test_tolerance();
        write_tolerance(16'hffff);
        send_command(kct_pkg::ModeDelete, 32'h0000_0000, 0, 0);
        write_tolerance(16'd0);
        send_command(kct_pkg::ModeDelete, curve_frame[0][31:0], 0, 0);
        write_tolerance(16'd1);
        send_command(kct_pkg::ModeDelete, curve_frame[0][31:0], 0, 0);
        write_tolerance(16'd4);
    endtask

    task automatic test_random(input int items);
        logic [31:0] base;
        logic [31:0] f;
        int          r;
        base = $urandom() & 32'hfff0_0000;
        for (int n = 0; n < items; n++) begin
            if (n == items / 3) begin
                wait_drained();
                write_tolerance(16'($urandom_range(0, 4096)));
            end
            if (n == items / 2) wait_drained();
            if (n == items - 200) begin
                send_idle_on = 0;
                recv_idle_on = 0;
            end
            // mostly keep frames near one window so evaluates hit segments
            f = ($urandom_range(0, 3) == 0) ? rand_word()
                                            : base + $urandom_range(0, 32'h000f_ffff);
            r = $urandom_range(0, 99);
            if (r < 2)
                send_command(kct_pkg::ModeClear, f, rand_word(), rand_word());
            else if (r < 40 && curve_count < kct_pkg::MaxKeys + 1)
                send_command(kct_pkg::ModeInsert, f, rand_word(), rand_word());
            else if (r < 55)
                send_command(kct_pkg::ModeDelete,
                             (curve_count > 0 && r < 50) ?
                             curve_frame[$urandom_range(0, curve_count - 1)][31:0] : f,
                             rand_word(), rand_word());
            else
                send_command(kct_pkg::ModeEval, f, rand_word(), rand_word());
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        curve_count = 0;
        tolerance = 16'd4;
        error_count = 0;
        send_idle_on = 1;
        recv_idle_on = 1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_tolerance();
        test_random(1100);
        wait_drained();
        if (error_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end
endmodule
`default_nettype wire
